// File: rtl/tsg_pkg.sv
`default_nettype none
package tsg_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_PERIOD    = 2'd0;
    localparam logic [1:0] CFG_WIDTH     = 2'd1;
    localparam logic [1:0] CFG_AMPLITUDE = 2'd2;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 17;

    // Field widths
    localparam int PERIOD_BITS = 16;
    localparam int WIDTH_BITS  = 17;
    localparam int AMP_BITS    = 15;
    localparam int OUT_BITS    = 16;

    // Register reset values
    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 16'd100;
    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 17'd65536;
    localparam logic [AMP_BITS-1:0]    AMP_RESET    = 15'd16384;
    localparam logic [WIDTH_BITS-1:0]  WIDTH_FULL   = 17'd65536;

    // Serial divider: 32-bit numerator over 16-bit divisor, 16-bit quotient
    localparam int DIV_STEPS    = 16;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);

    localparam int SAMPLE_BITS_DEFAULT = 16;

endpackage
`default_nettype wire

// File: rtl/tsg_div.sv
`default_nettype none
module tsg_div
    import tsg_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [2*DIV_STEPS-1:0] i_num,
    input  wire logic [DIV_STEPS-1:0]   i_den,
    output logic                        o_done,
    output logic [DIV_STEPS-1:0]        o_quot
);

    // Restoring division, one quotient bit per cycle. The caller guarantees
    // the quotient fits DIV_STEPS bits (upper numerator half below divisor).
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [DIV_STEPS-1:0]    r_rem;
    logic [DIV_STEPS-1:0]    r_quo;
    logic [DIV_STEPS-1:0]    r_den;
    logic                    r_done;
    logic [DIV_STEPS:0]      w_part;
    logic [DIV_STEPS:0]      w_trial;

    assign w_part  = {r_rem, r_quo[DIV_STEPS-1]};
    assign w_trial = w_part - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= DIV_CNT_BITS'(DIV_STEPS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_BITS'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[2*DIV_STEPS-1:DIV_STEPS];
            r_quo <= i_num[DIV_STEPS-1:0];
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            if (!w_trial[DIV_STEPS]) begin
                r_rem <= w_trial[DIV_STEPS-1:0];
                r_quo <= {r_quo[DIV_STEPS-2:0], 1'b1};
            end else begin
                r_rem <= w_part[DIV_STEPS-1:0];
                r_quo <= {r_quo[DIV_STEPS-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule
`default_nettype wire

// File: rtl/triangle_sawtooth_generator.sv
// Sequence from input transaction to result valid: a multiplier pass for the
//   rising length, a prepare step, a multiplier pass for the numerator, the
//   serial divider, a quotient capture and clamp, and an output load, which
//   waits while a previous result still waits.
// Ticks: a new tick is taken only in the idle state, after the previous sample
//   is loaded into the output register; the 16-step divider is the longest step.
// Reset (synchronous, active low): phase 0, period 100, width 65536,
//   amplitude 16384, no result pending.
`default_nettype none
module triangle_sawtooth_generator
    import tsg_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // configuration write channel
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    // tick channel
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic                      i_restart,
    // sample channel
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic signed [OUT_BITS-1:0]     o_sample,
    output logic [OUT_BITS-1:0]            o_phase
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;  // wait for a tick
    localparam logic [2:0] ST_RLEN = 3'd1;  // rising length = w * p >> 16
    localparam logic [2:0] ST_PREP = 3'd2;  // pick segment, offset, divisor
    localparam logic [2:0] ST_NUM  = 3'd3;  // numerator = offset * 2A, start divide
    localparam logic [2:0] ST_DIV  = 3'd4;  // wait for the quotient
    localparam logic [2:0] ST_OUT  = 3'd5;  // hand result to the output register

    // Clamp bounds of the signed SAMPLE_BITS range
    localparam logic signed [32:0] SMP_HI = (33'sd1 <<< (SAMPLE_BITS - 1)) - 33'sd1;
    localparam logic signed [32:0] SMP_LO = -SMP_HI - 33'sd1;

    logic [2:0]             r_state;

    // Configuration registers
    logic [PERIOD_BITS-1:0] r_cfg_period;
    logic [WIDTH_BITS-1:0]  r_cfg_width;
    logic [AMP_BITS-1:0]    r_cfg_amp;

    // Phase counter: position of the next sample
    logic [PERIOD_BITS-1:0] r_phase_count;

    // Working registers of one transaction
    logic [PERIOD_BITS-1:0] r_p;
    logic [WIDTH_BITS-1:0]  r_w;
    logic [AMP_BITS-1:0]    r_a;
    logic [PERIOD_BITS-1:0] r_t;
    logic [PERIOD_BITS-1:0] r_rlen;
    logic                   r_rising;
    logic [PERIOD_BITS-1:0] r_diff;
    logic [PERIOD_BITS-1:0] r_den;
    logic signed [OUT_BITS-1:0] r_res;

    // Output register
    logic                   r_out_valid;
    logic signed [OUT_BITS-1:0] r_out_sample;
    logic [OUT_BITS-1:0]    r_out_phase;

    // Shared multiplier
    logic [WIDTH_BITS-1:0]  w_mul_a;
    logic [PERIOD_BITS-1:0] w_mul_b;
    logic [WIDTH_BITS+PERIOD_BITS-1:0] w_prod;

    logic                   w_div_start;
    logic                   w_div_done;
    logic [DIV_STEPS-1:0]   w_quot;

    logic                   w_accept;
    logic                   w_out_load;
    logic signed [AMP_BITS+2:0] w_s;
    logic signed [32:0]     w_s_ext;
    logic signed [32:0]     w_s_clamp;
    logic [PERIOD_BITS:0]   w_t_next;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == ST_IDLE);
    assign w_accept    = i_valid && o_ready;
    assign w_out_load  = (r_state == ST_OUT) && (!r_out_valid || i_ready);
    assign w_div_start = (r_state == ST_NUM);

    // The multiplier serves both products; pick operands by state
    always_comb begin
        if (r_state == ST_RLEN) begin
            w_mul_a = r_w;
            w_mul_b = r_p;
        end else begin
            w_mul_a = {1'b0, r_diff};
            w_mul_b = {r_a, 1'b0};
        end
    end
    assign w_prod = w_mul_a * w_mul_b;

    tsg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_prod[2*DIV_STEPS-1:0]),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Rising: quotient - A. Falling: A - quotient. Then clamp.
    always_comb begin
        if (r_rising) begin
            w_s = $signed({2'b00, w_quot}) - $signed({3'b000, r_a});
        end else begin
            w_s = $signed({3'b000, r_a}) - $signed({2'b00, w_quot});
        end
        w_s_ext = 33'(w_s);
        if (w_s_ext > SMP_HI) begin
            w_s_clamp = SMP_HI;
        end else if (w_s_ext < SMP_LO) begin
            w_s_clamp = SMP_LO;
        end else begin
            w_s_clamp = w_s_ext;
        end
    end

    assign w_t_next = {1'b0, r_t} + 1'b1;

    // Configuration writes; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_period <= PERIOD_RESET;
            r_cfg_width  <= WIDTH_RESET;
            r_cfg_amp    <= AMP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PERIOD:    r_cfg_period <= i_cfg_data[PERIOD_BITS-1:0];
                CFG_WIDTH:     r_cfg_width  <= i_cfg_data[WIDTH_BITS-1:0];
                CFG_AMPLITUDE: r_cfg_amp    <= i_cfg_data[AMP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_phase_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_RLEN;
                    end
                end
                ST_RLEN: r_state <= ST_PREP;
                ST_PREP: r_state <= ST_NUM;
                ST_NUM:  r_state <= ST_DIV;
                ST_DIV: begin
                    if (w_div_done) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (w_out_load) begin
                        // Advance phase, wrap at the period
                        if (w_t_next >= {1'b0, r_p}) begin
                            r_phase_count <= '0;
                        end else begin
                            r_phase_count <= w_t_next[PERIOD_BITS-1:0];
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            // Zero period acts as one; width above one acts as one
            r_p <= (r_cfg_period == '0) ? PERIOD_BITS'(1) : r_cfg_period;
            r_w <= (r_cfg_width > WIDTH_FULL) ? WIDTH_FULL : r_cfg_width;
            r_a <= r_cfg_amp;
            // Restart, or a phase left beyond a lowered period, starts at zero
            if (i_restart || (r_phase_count >= r_cfg_period)) begin
                r_t <= '0;
            end else begin
                r_t <= r_phase_count;
            end
        end
        if (r_state == ST_RLEN) begin
            r_rlen <= w_prod[PERIOD_BITS+15:16];
        end
        if (r_state == ST_PREP) begin
            if (r_t < r_rlen) begin
                r_rising <= 1'b1;
                r_diff   <= r_t;
                r_den    <= r_rlen;
            end else begin
                r_rising <= 1'b0;
                r_diff   <= r_t - r_rlen;
                r_den    <= r_p - r_rlen;
            end
        end
        if ((r_state == ST_DIV) && w_div_done) begin
            r_res <= w_s_clamp[OUT_BITS-1:0];
        end
        if (w_out_load) begin
            r_out_sample <= r_res;
            r_out_phase  <= r_t;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_sample = r_out_sample;
    assign o_phase  = r_out_phase;

endmodule
`default_nettype wire

// File: rtl/tsg_chk.sv
`default_nettype none
module tsg_chk
    import tsg_pkg::*;
(
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_valid,
    input wire logic                      o_ready,
    input wire logic                      o_valid,
    input wire logic                      i_ready,
    input wire logic signed [OUT_BITS-1:0] o_sample,
    input wire logic [OUT_BITS-1:0]       o_phase
);

    logic                r_seen;
    logic [OUT_BITS-1:0] r_last_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (o_valid && i_ready) begin
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_valid && i_ready) begin
            r_last_phase <= o_phase;
        end
    end

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sample) && $stable(o_phase))
        else $error("stalled result changed");

    // One transaction at a time: drop ready after a tick is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready stayed high after tick transaction");

    // Phase advances by one or wraps to zero
    a_phase_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && r_seen |->
            (o_phase == r_last_phase + 1'b1) || (o_phase == '0))
        else $error("phase skipped");

    // Sample never reaches the most negative code
    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_sample != {1'b1, {(OUT_BITS-1){1'b0}}})
        else $error("sample out of range");

    // Reset empties the output
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind triangle_sawtooth_generator tsg_chk u_tsg_chk (.*);
`default_nettype wire
